FILE: rtl/edec_pkg.sv
// Package for the echo escape decoder: decode modes, character codes,
// the burst type passed from the decoder to the output stage, and helpers.
// No dependencies.
`timescale 1ns / 1ps

package edec_pkg;

	// Largest number of bytes one input item can produce.
	localparam int BURST_MAX = 5;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);

	// Configuration register indexes.
	localparam logic REG_ESCAPES = 1'b0;
	localparam logic REG_NL_SUP  = 1'b1;

	// Character codes used by the decoder.
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] ESC_CODE = 8'd27;

	// Decode modes; any other code behaves as text mode.
	typedef enum logic [2:0] {
		MODE_TEXT = 3'd0,
		MODE_ESC  = 3'd1,
		MODE_OCT  = 3'd2,
		MODE_HEX  = 3'd3
	} mode_t;

	// Bytes produced by one item, in emission order from index 0.
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
	} burst_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] val;
	} hex_t;

	// Value of a hex digit character, with a flag for a valid digit.
	function automatic hex_t hex_decode(logic [7:0] b);
		hex_t r;
		r.valid = 1'b1;
		r.val   = 4'h0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.val = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r.val = b[3:0] + 4'd9;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

	// Append one byte to a burst; bytes beyond the maximum are dropped.
	function automatic burst_t push_byte(burst_t b, logic [7:0] v);
		burst_t r;
		r = b;
		if (r.cnt < CNT_W'(BURST_MAX)) begin
			r.bytes[r.cnt] = v;
			r.cnt          = r.cnt + CNT_W'(1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/edec_decode.sv
// Escape decoder: holds the decode state and builds the burst of output
// bytes for each accepted item in one combinational pass. Uses edec_pkg.
`timescale 1ns / 1ps

module edec_decode
	import edec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       byte_present,
	input  logic       arg_end,
	input  logic       final_arg,
	input  logic       esc_en,
	input  logic       nl_sup,
	output burst_t     burst
);

	typedef struct packed {
		mode_t      mode;
		logic [1:0] dcnt;
		logic [7:0] acc;
		logic [7:0] held;
		logic       stopped;
	} state_t;

	state_t st_q;
	state_t nx;
	burst_t bo;
	logic   do_text;
	hex_t   hx;
	logic [7:0] hex_acc;

	// Leave any escape and return to text mode.
	function automatic state_t clear_esc(state_t s);
		state_t r;
		r      = s;
		r.mode = MODE_TEXT;
		r.dcnt = 2'd0;
		r.acc  = 8'h00;
		r.held = 8'h00;
		return r;
	endfunction

	// Emit a pending hex escape: its value, or the literal text if zero.
	function automatic burst_t hex_flush(burst_t b, state_t s);
		burst_t r;
		r = b;
		if (s.acc != 8'h00) begin
			r = push_byte(r, s.acc);
		end else begin
			r = push_byte(r, CH_BSL);
			r = push_byte(r, CH_X);
			if (s.dcnt != 2'd0) begin
				r = push_byte(r, s.held);
			end
		end
		return r;
	endfunction

	assign hx      = hex_decode(in_byte);
	assign hex_acc = {st_q.acc[3:0], hx.val};

	// Next state and output bytes for the item at the input.
	always_comb begin
		nx      = st_q;
		bo      = '0;
		do_text = 1'b0;
		if (byte_present) begin
			if (!esc_en) begin
				bo = push_byte(bo, in_byte);
			end else begin
				unique case (st_q.mode)
					MODE_ESC: begin
						nx.mode = MODE_TEXT;
						case (in_byte)
							CH_BSL:  bo = push_byte(bo, 8'd92);
							8'h61:   bo = push_byte(bo, 8'd7);   // a
							8'h62:   bo = push_byte(bo, 8'd8);   // b
							8'h65:   bo = push_byte(bo, ESC_CODE); // e
							8'h66:   bo = push_byte(bo, 8'd12);  // f
							8'h6E:   bo = push_byte(bo, 8'd10);  // n
							8'h72:   bo = push_byte(bo, 8'd13);  // r
							8'h74:   bo = push_byte(bo, 8'd9);   // t
							8'h76:   bo = push_byte(bo, 8'd11);  // v
							CH_C:    nx.stopped = 1'b1;
							CH_ZERO: begin
								nx      = clear_esc(nx);
								nx.mode = MODE_OCT;
							end
							CH_X: begin
								nx      = clear_esc(nx);
								nx.mode = MODE_HEX;
							end
							default: bo = push_byte(bo, in_byte);
						endcase
					end
					MODE_OCT: begin
						if (in_byte[7:3] == 5'b00110) begin
							nx.acc = {st_q.acc[4:0], in_byte[2:0]};
							if (st_q.dcnt >= 2'd2) begin
								bo = push_byte(bo, nx.acc);
								nx = clear_esc(nx);
							end else begin
								nx.dcnt = st_q.dcnt + 2'd1;
							end
						end else begin
							bo      = push_byte(bo, st_q.acc);
							nx      = clear_esc(nx);
							do_text = 1'b1;
						end
					end
					MODE_HEX: begin
						if (hx.valid) begin
							if (st_q.dcnt == 2'd0) begin
								nx.held = in_byte;
								nx.acc  = {4'h0, hx.val};
								nx.dcnt = 2'd1;
							end else begin
								if (hex_acc != 8'h00) begin
									bo = push_byte(bo, hex_acc);
								end else begin
									bo = push_byte(bo, CH_BSL);
									bo = push_byte(bo, CH_X);
									bo = push_byte(bo, st_q.held);
									bo = push_byte(bo, in_byte);
								end
								nx = clear_esc(nx);
							end
						end else begin
							bo      = hex_flush(bo, st_q);
							nx      = clear_esc(nx);
							do_text = 1'b1;
						end
					end
					default: begin
						nx.mode = MODE_TEXT;
						do_text = 1'b1;
					end
				endcase
				// Plain text handling, also for a byte that closed an escape.
				if (do_text && !nx.stopped) begin
					if (in_byte == CH_BSL) begin
						nx.mode = MODE_ESC;
					end else begin
						bo = push_byte(bo, in_byte);
					end
				end
			end
		end
		// End of argument: finish a pending escape, then the separator.
		if (arg_end) begin
			if (esc_en) begin
				case (nx.mode)
					MODE_ESC: bo = push_byte(bo, CH_BSL);
					MODE_OCT: bo = push_byte(bo, nx.acc);
					MODE_HEX: bo = hex_flush(bo, nx);
					default:  ;
				endcase
			end
			nx         = clear_esc(nx);
			nx.stopped = 1'b0;
			if (!final_arg) begin
				bo = push_byte(bo, CH_SPACE);
			end else if (!nl_sup) begin
				bo = push_byte(bo, CH_NL);
			end
		end
	end

	assign burst = bo;

	// Decode state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	// An octal escape always ends before a third digit is held.
	a_oct_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_OCT |-> st_q.dcnt != 2'd3)
		else $error("octal escape holds too many digits");

	// A hex escape holds at most one digit between items.
	a_hex_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_HEX |-> st_q.dcnt <= 2'd1)
		else $error("hex escape holds too many digits");

	// Raw mode gives at most the byte and a separator.
	a_raw_len: assert property (@(posedge clk) disable iff (!arst_n)
		!esc_en |-> bo.cnt <= CNT_W'(2))
		else $error("raw mode produced more than two bytes");

endmodule

FILE: rtl/edec_burst.sv
// Output stage: holds the burst of one item and hands its bytes out one
// transfer at a time; decides when the next item can be taken. Uses edec_pkg.
`timescale 1ns / 1ps

module edec_burst
	import edec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  burst_t     burst,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic [BURST_MAX-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      out_fire;
	logic                      in_fire;
	logic                      load;

	assign out_valid = cnt_q != '0;
	assign out_byte  = bytes_q[0];
	assign run_last  = cnt_q == CNT_W'(1);
	assign out_fire  = out_valid && !out_stall;

	// A new item is taken when the buffer is empty or its last byte leaves now.
	assign in_stall = !((cnt_q == '0) || (run_last && !out_stall));
	assign in_fire  = in_valid && !in_stall;
	assign load     = in_fire && (burst.cnt != '0);

	// Burst buffer: load a new burst or shift out one byte per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (out_fire) begin
			bytes_q <= bytes_q >> 8;
		end
	end

	// The count never exceeds the largest burst.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BURST_MAX))
		else $error("burst count out of range");

	// No item is taken in the middle of a burst.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> in_stall)
		else $error("input taken while a burst is still pending");

	// A loaded burst is offered in the next cycle with its full length.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && cnt_q == $past(burst.cnt))
		else $error("burst not presented after load");

endmodule

FILE: rtl/echo_escape_decoder.sv
// Echo escape decoder, top level: configuration registers, decoder, output.
// The first result byte of an item is offered in the cycle after its transfer.
// One output byte per cycle while not stalled; an item producing n bytes
// (up to 5) is followed by the next item in the cycle its last byte transfers.
// Items producing no bytes are taken every cycle when the output is empty.
// Reset (arst_n low) clears the decode state, the burst buffer and both registers.
`timescale 1ns / 1ps

module echo_escape_decoder
	import edec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       byte_present,
	input  logic       arg_end,
	input  logic       final_arg,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic       wr_data
);

	logic   esc_en_q;
	logic   nl_sup_q;
	logic   in_fire;
	burst_t burst;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_en_q <= 1'b0;
			nl_sup_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ESCAPES: esc_en_q <= wr_data;
				REG_NL_SUP:  nl_sup_q <= wr_data;
				default:     ;
			endcase
		end
	end

	assign in_fire = in_valid && !in_stall;

	// Decoder state and burst construction.
	edec_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (in_fire),
		.in_byte      (in_byte),
		.byte_present (byte_present),
		.arg_end      (arg_end),
		.final_arg    (final_arg),
		.esc_en       (esc_en_q),
		.nl_sup       (nl_sup_q),
		.burst        (burst)
	);

	// Result buffer and output handshake.
	edec_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.burst     (burst),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule
